### design/assert_macros.svh
// assertion macros used by the checker file
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/i2cms_pkg.sv
// types and codes for the i2c master register sequencer
// no dependencies; used by the step logic, the top level and the checker
package i2cms_pkg;

  // request kinds
  typedef enum logic [1:0] {
    REQ_BEGIN_WR  = 2'd0,
    REQ_BEGIN_RD  = 2'd1,
    REQ_BUS_DONE  = 2'd2,
    REQ_NEXT_BYTE = 2'd3
  } req_type_t;

  // bus commands
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_SEND    = 3'd3,
    CMD_RECV    = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_NAK     = 3'd6,
    CMD_STOP    = 3'd7
  } bus_cmd_t;

  // completion status codes
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_ADDR_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_REG_NAK        = 3'd2;
  localparam logic [2:0] ST_DATA_NAK       = 3'd3;
  localparam logic [2:0] ST_RADDR_NAK      = 3'd4;

  // configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_ATTEMPTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RD_ATTEMPTS = 1'd1;
  localparam logic [2:0] WR_ATTEMPTS_RST = 3'd5;
  localparam logic [2:0] RD_ATTEMPTS_RST = 3'd6;

  // transaction phase, one-hot
  typedef enum logic [10:0] {
    PH_IDLE      = 11'b000_0000_0001,
    PH_START     = 11'b000_0000_0010,
    PH_ADDR      = 11'b000_0000_0100,
    PH_REG       = 11'b000_0000_1000,
    PH_WAIT_DATA = 11'b000_0001_0000,
    PH_DATA      = 11'b000_0010_0000,
    PH_RESTART   = 11'b000_0100_0000,
    PH_RADDR     = 11'b000_1000_0000,
    PH_RECV      = 11'b001_0000_0000,
    PH_ACKED     = 11'b010_0000_0000,
    PH_STOP      = 11'b100_0000_0000
  } phase_t;

  // request payload
  typedef struct packed {
    req_type_t  req_type;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic       bus_nak;
    logic [7:0] bus_rx_byte;
  } in_req_t;

  // result payload
  typedef struct packed {
    bus_cmd_t   bus_cmd;
    logic [7:0] tx_byte;
    logic       want_data;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_last;
    logic       done_res;
    logic [2:0] status;
  } out_res_t;

  // sequencer state
  typedef struct packed {
    phase_t     phase;
    logic       is_read;
    logic [7:0] slave_byte;
    logic [7:0] register_byte;
    logic [7:0] bytes_left;
    logic [2:0] attempts_used;
    logic [2:0] pending_status;
  } seq_state_t;

  // address attempt limits
  typedef struct packed {
    logic [2:0] wr_attempts;
    logic [2:0] rd_attempts;
  } cfg_lim_t;

endpackage

### design/i2cms_step.sv
// next-state and result logic for one request of the sequencer
// depends on i2cms_pkg
module i2cms_step (
  input  i2cms_pkg::seq_state_t cur,
  input  i2cms_pkg::in_req_t    req,
  input  i2cms_pkg::cfg_lim_t   lim,
  output i2cms_pkg::seq_state_t nxt,
  output i2cms_pkg::out_res_t   res
);

  logic [2:0] limit;
  logic [2:0] att_inc;

  // attempt bookkeeping for the address phase
  assign limit   = cur.is_read ? lim.rd_attempts : lim.wr_attempts;
  assign att_inc = cur.attempts_used + 3'd1;

  // decode the request against the current phase
  always_comb begin
    nxt = cur;
    res = '0;
    unique case (req.req_type)
      i2cms_pkg::REQ_BEGIN_WR, i2cms_pkg::REQ_BEGIN_RD: begin
        if (cur.phase == i2cms_pkg::PH_IDLE) begin
          nxt.is_read        = (req.req_type == i2cms_pkg::REQ_BEGIN_RD);
          nxt.slave_byte     = req.slave_addr;
          nxt.register_byte  = req.reg_addr;
          nxt.bytes_left     = req.length;
          if ((req.req_type == i2cms_pkg::REQ_BEGIN_RD) && (req.length == 8'd0)) begin
            nxt.bytes_left = 8'd1;
          end
          nxt.attempts_used  = 3'd0;
          nxt.pending_status = i2cms_pkg::ST_OK;
          res.bus_cmd        = i2cms_pkg::CMD_START;
          nxt.phase          = i2cms_pkg::PH_START;
        end
      end
      i2cms_pkg::REQ_NEXT_BYTE: begin
        if (cur.phase == i2cms_pkg::PH_WAIT_DATA) begin
          nxt.bytes_left = cur.bytes_left - 8'd1;
          res.bus_cmd    = i2cms_pkg::CMD_SEND;
          res.tx_byte    = req.data_byte;
          nxt.phase      = i2cms_pkg::PH_DATA;
        end
      end
      i2cms_pkg::REQ_BUS_DONE: begin
        unique case (cur.phase)
          i2cms_pkg::PH_START: begin
            res.bus_cmd = i2cms_pkg::CMD_SEND;
            res.tx_byte = cur.slave_byte;
            nxt.phase   = i2cms_pkg::PH_ADDR;
          end
          i2cms_pkg::PH_ADDR: begin
            if (req.bus_nak) begin
              nxt.attempts_used = att_inc;
              if (att_inc >= limit) begin
                nxt.pending_status = i2cms_pkg::ST_ADDR_EXHAUSTED;
                res.bus_cmd        = i2cms_pkg::CMD_STOP;
                nxt.phase          = i2cms_pkg::PH_STOP;
              end else begin
                res.bus_cmd = i2cms_pkg::CMD_START;
                nxt.phase   = i2cms_pkg::PH_START;
              end
            end else begin
              res.bus_cmd = i2cms_pkg::CMD_SEND;
              res.tx_byte = cur.register_byte;
              nxt.phase   = i2cms_pkg::PH_REG;
            end
          end
          i2cms_pkg::PH_REG: begin
            if (req.bus_nak) begin
              nxt.pending_status = i2cms_pkg::ST_REG_NAK;
              res.bus_cmd        = i2cms_pkg::CMD_STOP;
              nxt.phase          = i2cms_pkg::PH_STOP;
            end else if (cur.is_read) begin
              res.bus_cmd = i2cms_pkg::CMD_RESTART;
              nxt.phase   = i2cms_pkg::PH_RESTART;
            end else if (cur.bytes_left == 8'd0) begin
              nxt.pending_status = i2cms_pkg::ST_OK;
              res.bus_cmd        = i2cms_pkg::CMD_STOP;
              nxt.phase          = i2cms_pkg::PH_STOP;
            end else begin
              res.want_data = 1'b1;
              nxt.phase     = i2cms_pkg::PH_WAIT_DATA;
            end
          end
          i2cms_pkg::PH_DATA: begin
            if (req.bus_nak) begin
              nxt.pending_status = i2cms_pkg::ST_DATA_NAK;
              res.bus_cmd        = i2cms_pkg::CMD_STOP;
              nxt.phase          = i2cms_pkg::PH_STOP;
            end else if (cur.bytes_left == 8'd0) begin
              nxt.pending_status = i2cms_pkg::ST_OK;
              res.bus_cmd        = i2cms_pkg::CMD_STOP;
              nxt.phase          = i2cms_pkg::PH_STOP;
            end else begin
              res.want_data = 1'b1;
              nxt.phase     = i2cms_pkg::PH_WAIT_DATA;
            end
          end
          i2cms_pkg::PH_RESTART: begin
            res.bus_cmd = i2cms_pkg::CMD_SEND;
            res.tx_byte = cur.slave_byte + 8'd1;
            nxt.phase   = i2cms_pkg::PH_RADDR;
          end
          i2cms_pkg::PH_RADDR: begin
            if (req.bus_nak) begin
              nxt.pending_status = i2cms_pkg::ST_RADDR_NAK;
              res.bus_cmd        = i2cms_pkg::CMD_STOP;
              nxt.phase          = i2cms_pkg::PH_STOP;
            end else begin
              res.bus_cmd = i2cms_pkg::CMD_RECV;
              nxt.phase   = i2cms_pkg::PH_RECV;
            end
          end
          i2cms_pkg::PH_RECV: begin
            res.rx_valid = 1'b1;
            res.rx_data  = req.bus_rx_byte;
            if (cur.bytes_left <= 8'd1) begin
              res.rx_last    = 1'b1;
              nxt.bytes_left = 8'd0;
              res.bus_cmd    = i2cms_pkg::CMD_NAK;
            end else begin
              nxt.bytes_left = cur.bytes_left - 8'd1;
              res.bus_cmd    = i2cms_pkg::CMD_ACK;
            end
            nxt.phase = i2cms_pkg::PH_ACKED;
          end
          i2cms_pkg::PH_ACKED: begin
            if (cur.bytes_left == 8'd0) begin
              nxt.pending_status = i2cms_pkg::ST_OK;
              res.bus_cmd        = i2cms_pkg::CMD_STOP;
              nxt.phase          = i2cms_pkg::PH_STOP;
            end else begin
              res.bus_cmd = i2cms_pkg::CMD_RECV;
              nxt.phase   = i2cms_pkg::PH_RECV;
            end
          end
          i2cms_pkg::PH_STOP: begin
            res.done_res = 1'b1;
            res.status   = cur.pending_status;
            nxt.phase    = i2cms_pkg::PH_IDLE;
          end
          // idle or waiting for data: bus event is ignored
          i2cms_pkg::PH_IDLE, i2cms_pkg::PH_WAIT_DATA: begin
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

### design/i2c_master_register_sequencer.sv
// top level of the i2c master register sequencer: state, limits and result register
// depends on i2cms_pkg and i2cms_step
//
//   channel  handshake             payload
//   in       in_valid / in_ready   in_req  (i2cms_pkg::in_req_t)
//   out      out_valid / out_ready out_res (i2cms_pkg::out_res_t)
//   cfg      cfg_we                cfg_index, cfg_wdata
//
// one request per clock while in_ready is high; its result is registered and shows the cycle after acceptance
// the state machine and one result register set the rate: one request, one result
// in_ready is low only while a result sits in the output register with out_ready low
// reset is synchronous: idle phase, limits back to 5 write and 6 read attempts
module i2c_master_register_sequencer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  i2cms_pkg::in_req_t                    in_req,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output i2cms_pkg::out_res_t                   out_res,
  input  logic                                  cfg_we,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [i2cms_pkg::CFG_DAT_W-1:0]       cfg_wdata
);

  i2cms_pkg::seq_state_t state_r;
  i2cms_pkg::seq_state_t state_nxt;
  i2cms_pkg::cfg_lim_t   lim_r;
  i2cms_pkg::out_res_t   res_nxt;
  i2cms_pkg::out_res_t   out_res_r;
  logic                  out_valid_r;
  logic                  accept;

  // handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // per-request decode
  i2cms_step u_step (
    .cur (state_r),
    .req (in_req),
    .lim (lim_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.wr_attempts <= i2cms_pkg::WR_ATTEMPTS_RST;
      lim_r.rd_attempts <= i2cms_pkg::RD_ATTEMPTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cms_pkg::CFG_WR_ATTEMPTS: lim_r.wr_attempts <= cfg_wdata;
        i2cms_pkg::CFG_RD_ATTEMPTS: lim_r.rd_attempts <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase          <= i2cms_pkg::PH_IDLE;
      state_r.is_read        <= 1'b0;
      state_r.slave_byte     <= 8'd0;
      state_r.register_byte  <= 8'd0;
      state_r.bytes_left     <= 8'd0;
      state_r.attempts_used  <= 3'd0;
      state_r.pending_status <= i2cms_pkg::ST_OK;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

### design/i2cms_checker.sv
// port-level checks for the i2c master register sequencer, bound to the top level
// depends on i2cms_pkg and assert_macros.svh
`include "assert_macros.svh"

module i2cms_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input i2cms_pkg::out_res_t             out_res
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_res), "result changed while stalled")

  // every accepted request yields a result on the next cycle
  `ASSERT_NEXT(a_req_to_res, in_valid && in_ready, out_valid, "accepted request gave no result")

  // status only accompanies completion
  `ASSERT_IMPLIES(a_status_done, out_valid && !out_res.done_res, out_res.status == i2cms_pkg::ST_OK, "status without done")

  // receive fields are clean without a received byte
  `ASSERT_IMPLIES(a_rx_clean, out_valid && !out_res.rx_valid, (out_res.rx_data == 8'd0) && !out_res.rx_last, "stray receive data")

  // tx byte only with a send command
  `ASSERT_IMPLIES(a_tx_clean, out_valid && (out_res.bus_cmd != i2cms_pkg::CMD_SEND), out_res.tx_byte == 8'd0, "stray tx byte")

endmodule

bind i2c_master_register_sequencer i2cms_checker u_i2cms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_res   (out_res)
);
